>>> rtl/core/rad_pkg.sv
// Shared types and constants for the ring array deque.
package rad_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned INDEX_W = 4;
  localparam int unsigned FILL_W  = 5;

  typedef enum logic [1:0] {
    OP_PUSH      = 2'd0,
    OP_POP_FRONT = 2'd1,
    OP_POP_BACK  = 2'd2,
    OP_READ_AT   = 2'd3
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [VALUE_W-1:0] push_value;
    logic [INDEX_W-1:0] index;
  } in_item_t;

  typedef struct packed {
    logic               ok;
    logic [VALUE_W-1:0] read_value;
    logic [FILL_W-1:0]  fill_count;
  } out_item_t;

  // Result control carried from the pointer logic to the output stage.
  typedef struct packed {
    logic valid;
    logic ok;
    logic rd_ok;
  } resp_t;

endpackage

>>> rtl/core/rad_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rad_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/rad_ctrl.sv
// Head and count registers, ring address generation and result control.
module rad_ctrl #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned ELEM_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  rad_pkg::in_item_t           in_item,
  output logic                        busy,
  output logic                        mem_we,
  output logic [$clog2(CAPACITY)-1:0] mem_waddr,
  output logic [ELEM_WIDTH-1:0]       mem_wdata,
  output logic                        mem_re,
  output logic [$clog2(CAPACITY)-1:0] mem_raddr,
  output rad_pkg::resp_t              resp,
  output logic [$clog2(CAPACITY+1)-1:0] count
);

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > rad_pkg::INDEX_W) ? CW : rad_pkg::INDEX_W;
  localparam int unsigned DW   = (ELEM_WIDTH > rad_pkg::VALUE_W) ? ELEM_WIDTH
                                                                 : rad_pkg::VALUE_W;
  localparam logic [AW:0]   CAP_S   = CAPACITY[AW:0];
  localparam logic [CW-1:0] CAP_C   = CAPACITY[CW-1:0];
  localparam logic [AW-1:0] LAST_AD = AW'(CAPACITY - 1);

  logic [AW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  rad_pkg::resp_t  resp_r, resp_nxt;

  logic            accept;
  logic            is_full, is_empty, idx_ok;
  logic [CMPW-1:0] idx_ext, cnt_ext;
  logic [AW:0]     tail_sum, rd_sum;
  logic [AW-1:0]   tail_ad, rd_ad, head_inc;
  logic [DW-1:0]   value_wide;

  assign accept   = start && !busy;
  assign busy     = 1'b0;
  assign is_full  = (count_r == CAP_C);
  assign is_empty = (count_r == '0);
  assign idx_ext  = CMPW'(in_item.index);
  assign cnt_ext  = CMPW'(count_r);
  assign idx_ok   = (idx_ext < cnt_ext);

  // Wrap head + offset; offset stays below the capacity whenever it is used.
  assign tail_sum = {1'b0, head_r} + {1'b0, count_r[AW-1:0]};
  assign tail_ad  = (tail_sum >= CAP_S) ? AW'(tail_sum - CAP_S) : tail_sum[AW-1:0];
  assign rd_sum   = {1'b0, head_r} + {1'b0, idx_ext[AW-1:0]};
  assign rd_ad    = (rd_sum >= CAP_S) ? AW'(rd_sum - CAP_S) : rd_sum[AW-1:0];
  assign head_inc = (head_r == LAST_AD) ? '0 : head_r + 1'b1;

  assign value_wide = DW'(in_item.push_value);
  assign mem_wdata  = value_wide[ELEM_WIDTH-1:0];
  assign mem_waddr  = tail_ad;
  assign mem_raddr  = rd_ad;

  always_comb begin
    head_nxt       = head_r;
    count_nxt      = count_r;
    resp_nxt       = '0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    resp_nxt.valid = accept;
    if (accept) begin
      case (in_item.op)
        rad_pkg::OP_PUSH: begin
          if (!is_full) begin
            mem_we      = 1'b1;
            count_nxt   = count_r + 1'b1;
            resp_nxt.ok = 1'b1;
          end
        end
        rad_pkg::OP_POP_FRONT: begin
          if (!is_empty) begin
            head_nxt    = head_inc;
            count_nxt   = count_r - 1'b1;
            resp_nxt.ok = 1'b1;
          end
        end
        rad_pkg::OP_POP_BACK: begin
          if (!is_empty) begin
            count_nxt   = count_r - 1'b1;
            resp_nxt.ok = 1'b1;
          end
        end
        default: begin
          if (idx_ok) begin
            mem_re         = 1'b1;
            resp_nxt.ok    = 1'b1;
            resp_nxt.rd_ok = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      resp_r  <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      resp_r  <= resp_nxt;
    end
  end

  assign resp  = resp_r;
  assign count = count_r;

endmodule

>>> rtl/core/ring_array_deque_core.sv
// Ring array deque: top level with pointer control, element RAM and result mapping.
//
// Usage: drive an operation on in_item and raise start; the transfer takes place
// at a rising edge with start high and busy low. busy stays low, so a new
// operation may follow in every cycle.
// Operations: push at the tail, pop front, pop back, read at a logical index
// from the head (index 0 is the front). Full, empty and out-of-range cases
// return ok low and leave the ring untouched.
// Result: the result appears on out_item, marked by out_valid, in the cycle
// after the transfer and stays there for exactly that cycle. The read goes
// through the registered port of the element RAM; head and count update in
// the transfer cycle, so throughput is one operation per cycle.
// fill_count reports the element count after the operation.
// Reset (rst_n low, synchronous) empties the ring and clears the head; the
// element RAM keeps its contents and needs no clearing since only written
// entries below the count are ever read.
// The receiver cannot stall: every result is taken in its strobe cycle.
module ring_array_deque_core #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned ELEM_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  rad_pkg::in_item_t  in_item,
  output logic               busy,
  output logic               out_valid,
  output rad_pkg::out_item_t out_item
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned DW = (ELEM_WIDTH > rad_pkg::VALUE_W) ? ELEM_WIDTH
                                                               : rad_pkg::VALUE_W;
  localparam int unsigned FXW = (CW > rad_pkg::FILL_W) ? CW : rad_pkg::FILL_W;

  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [ELEM_WIDTH-1:0] mem_wdata, mem_rdata;
  rad_pkg::resp_t        resp;
  logic [CW-1:0]         count;
  logic [DW-1:0]         rdata_wide;
  logic [FXW-1:0]        count_wide;

  rad_ctrl #(
    .CAPACITY   (CAPACITY),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .resp      (resp),
    .count     (count)
  );

  rad_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rdata_wide = DW'(mem_rdata);
  assign count_wide = FXW'(count);

  assign out_valid           = resp.valid;
  assign out_item.ok         = resp.ok;
  assign out_item.read_value = resp.rd_ok ? rdata_wide[rad_pkg::VALUE_W-1:0] : '0;
  assign out_item.fill_count = count_wide[rad_pkg::FILL_W-1:0];

  // Every transfer yields a result in the next cycle, and only then.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("missing result after transfer");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result without transfer");

  // A failed operation must leave the count unchanged.
  a_fail_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.ok) |-> (count == $past(count)))
    else $error("count changed on failed operation");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count <= CW'(CAPACITY))
    else $error("count exceeds capacity");

endmodule

>>> sim/tb_ring_array_deque_core.sv
// Self-checking testbench for ring_array_deque_core: directed table plus random op mix.
`timescale 1ns / 100ps

module tb_ring_array_deque_core;
  import rad_pkg::*;

  localparam int DEPTH       = 16;
  localparam int RAND_ITEMS  = 750;
  localparam int QUIET_TAIL  = 100;
  localparam int STALL_LIMIT = 500;
  localparam int DIR_ROWS    = 18;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN, MIX_READ} mix_t;

  typedef struct {
    op_t         op;
    logic [31:0] val;
    logic [3:0]  idx;
    int          rpt;
    bit          chk;
    out_item_t   want;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  in_item_t  in_item;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  // typed-in expectation that travels with the item being offered
  bit        row_chk;
  out_item_t row_want;

  logic [VALUE_W-1:0] ring_elems [DEPTH];
  logic [INDEX_W-1:0] ring_head = '0;
  logic [FILL_W-1:0]  ring_fill = '0;
  out_item_t          ring_resp_q [$];

  int drv_fill;
  int errors;
  int n_checked;
  int n_refused;
  int op_hits [4];
  int idle_run;

  dir_row_t dir_tab [DIR_ROWS];

  wire xfer = (rst_n === 1'b1) && (start === 1'b1) && (busy === 1'b0);

  ring_array_deque_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_item  (in_item),
    .busy     (busy),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic out_item_t ring_step(in_item_t it);
    out_item_t r;
    logic [INDEX_W-1:0] pos;
    r = '0;
    case (it.op)
      OP_PUSH: if (ring_fill < DEPTH) begin
        pos = ring_head + ring_fill[INDEX_W-1:0];
        ring_elems[pos] = it.push_value;
        ring_fill = ring_fill + 1'b1;
        r.ok = 1'b1;
      end
      OP_POP_FRONT: if (ring_fill != 0) begin
        ring_head = ring_head + 1'b1;
        ring_fill = ring_fill - 1'b1;
        r.ok = 1'b1;
      end
      OP_POP_BACK: if (ring_fill != 0) begin
        ring_fill = ring_fill - 1'b1;
        r.ok = 1'b1;
      end
      OP_READ_AT: if ({1'b0, it.index} < ring_fill) begin
        pos = ring_head + it.index;
        r.read_value = ring_elems[pos];
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.fill_count = ring_fill;
    return r;
  endfunction

  function automatic dir_row_t mk(op_t op, logic [31:0] val, logic [3:0] idx, int rpt,
                                  bit chk, logic ok, logic [31:0] rv, logic [4:0] fc);
    dir_row_t d;
    d.op   = op;
    d.val  = val;
    d.idx  = idx;
    d.rpt  = rpt;
    d.chk  = chk;
    d.want = '{ok: ok, read_value: rv, fill_count: fc};
    return d;
  endfunction

  // check results and predict at each transfer, in one process
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (rst_n === 1'b1) begin
      if (out_valid === 1'b1) begin
        if (ring_resp_q.size() == 0) begin
          $display("%0t: result with nothing pending: ok=%0b read_value=%h fill_count=%0d",
                   $time, out_item.ok, out_item.read_value, out_item.fill_count);
          errors++;
        end else begin
          want = ring_resp_q.pop_front();
          n_checked++;
          if (out_item.ok !== want.ok) begin
            $display("%0t: ok expected %0b actual %0b", $time, want.ok, out_item.ok);
            errors++;
          end
          if (out_item.read_value !== want.read_value) begin
            $display("%0t: read_value expected %h actual %h",
                     $time, want.read_value, out_item.read_value);
            errors++;
          end
          if (out_item.fill_count !== want.fill_count) begin
            $display("%0t: fill_count expected %0d actual %0d",
                     $time, want.fill_count, out_item.fill_count);
            errors++;
          end
        end
      end else if (out_valid !== 1'b0) begin
        $display("%0t: out_valid expected 0 actual %b", $time, out_valid);
        errors++;
      end
      if (xfer) begin
        got = ring_step(in_item);
        want = row_chk ? row_want : got;
        if (!want.ok) n_refused++;
        op_hits[in_item.op]++;
        ring_resp_q.push_back(want);
      end
    end
  end

  always @(posedge clk) begin
    if (xfer || out_valid === 1'b1) idle_run <= 0;
    else idle_run <= idle_run + 1;
    if (idle_run >= STALL_LIMIT) begin
      $display("Watchdog: %0d cycles without a transfer, %0d results pending",
               idle_run, ring_resp_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_op(input in_item_t it, input bit chk, input out_item_t want);
    start    <= 1'b1;
    in_item  <= it;
    row_chk  <= chk;
    row_want <= want;
    do @(posedge clk); while (!xfer);
    case (it.op)
      OP_PUSH:      if (drv_fill < DEPTH) drv_fill++;
      OP_POP_FRONT,
      OP_POP_BACK:  if (drv_fill > 0) drv_fill--;
      default: ;
    endcase
  endtask

  // hold the sender until every pending result has come back
  task automatic drain_wait();
    start <= 1'b0;
    do @(negedge clk); while (ring_resp_q.size() != 0);
    @(posedge clk);
  endtask

  initial begin
    in_item_t    it;
    mix_t        mode;
    int          seg_left;
    bit          idle_on;
    int          roll;
    int          t0, t1, t2;
    logic [31:0] val;

    rst_n    <= 1'b0;
    start    <= 1'b0;
    in_item  <= '0;
    row_chk  <= 1'b0;
    row_want <= '0;
    drv_fill  = 0;

    dir_tab = '{
      mk(OP_READ_AT,   32'h0,         4'd0,  1,  1, 0, 32'h0,         5'd0),
      mk(OP_READ_AT,   32'h0,         4'd15, 1,  1, 0, 32'h0,         5'd0),
      mk(OP_POP_FRONT, 32'h0,         4'd0,  1,  1, 0, 32'h0,         5'd0),
      mk(OP_POP_BACK,  32'h0,         4'd0,  1,  1, 0, 32'h0,         5'd0),
      mk(OP_PUSH,      32'hFFFF_FFFF, 4'd0,  1,  1, 1, 32'h0,         5'd1),
      mk(OP_PUSH,      32'h0,         4'd15, 1,  1, 1, 32'h0,         5'd2),
      mk(OP_READ_AT,   32'h0,         4'd0,  1,  1, 1, 32'hFFFF_FFFF, 5'd2),
      mk(OP_READ_AT,   32'h0,         4'd1,  1,  1, 1, 32'h0,         5'd2),
      mk(OP_READ_AT,   32'h0,         4'd2,  1,  1, 0, 32'h0,         5'd2),
      mk(OP_POP_FRONT, 32'h0,         4'd0,  1,  1, 1, 32'h0,         5'd1),
      // last pop still advances the head; the next push lands at the new head
      mk(OP_POP_FRONT, 32'h0,         4'd0,  1,  1, 1, 32'h0,         5'd0),
      mk(OP_PUSH,      32'h1234_5678, 4'd0,  1,  1, 1, 32'h0,         5'd1),
      mk(OP_READ_AT,   32'h0,         4'd0,  1,  1, 1, 32'h1234_5678, 5'd1),
      // fill to capacity, wrapping past the top position
      mk(OP_PUSH,      32'h8000_0001, 4'd0,  15, 0, 0, 32'h0,         5'd0),
      mk(OP_PUSH,      32'h5555_5555, 4'd0,  1,  1, 0, 32'h0,         5'd16),
      mk(OP_READ_AT,   32'h0,         4'd15, 1,  0, 0, 32'h0,         5'd0),
      mk(OP_POP_BACK,  32'h0,         4'd0,  1,  1, 1, 32'h0,         5'd15),
      mk(OP_READ_AT,   32'h0,         4'd15, 1,  1, 0, 32'h0,         5'd15)
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[r]) begin
      for (int k = 0; k < dir_tab[r].rpt; k++) begin
        it.op         = dir_tab[r].op;
        it.push_value = dir_tab[r].val + k;
        it.index      = dir_tab[r].idx;
        send_op(it, dir_tab[r].chk, dir_tab[r].want);
      end
    end
    drain_wait();

    seg_left = 0;
    mode     = MIX_EVEN;
    idle_on  = 1'b0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (seg_left == 0) begin
        mode     = mix_t'($urandom_range(0, 3));
        seg_left = $urandom_range(20, 60);
        idle_on  = ($urandom_range(0, 3) != 0);
      end
      seg_left--;
      if (n == RAND_ITEMS / 2) drain_wait();
      if (idle_on && n < RAND_ITEMS - QUIET_TAIL && $urandom_range(0, 5) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end

      case (mode)
        MIX_FILL:  begin t0 = 70; t1 = 80; t2 = 88; end
        MIX_DRAIN: begin t0 = 20; t1 = 55; t2 = 80; end
        MIX_EVEN:  begin t0 = 35; t1 = 55; t2 = 70; end
        default:   begin t0 = 20; t1 = 30; t2 = 40; end
      endcase
      roll  = $urandom_range(0, 99);
      it.op = (roll < t0) ? OP_PUSH :
              (roll < t1) ? OP_POP_FRONT :
              (roll < t2) ? OP_POP_BACK : OP_READ_AT;

      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0:       val = '0;
          1:       val = '1;
          2:       val = 32'h1 << $urandom_range(0, 31);
          default: val = ~(32'h1 << $urandom_range(0, 31));
        endcase
      end else begin
        val = $urandom;
      end
      it.push_value = val;

      // aim most reads at live entries
      if (drv_fill != 0 && $urandom_range(0, 3) != 0) begin
        it.index = INDEX_W'($urandom_range(0, drv_fill - 1));
      end else begin
        it.index = INDEX_W'($urandom_range(0, 15));
      end

      send_op(it, 1'b0, '0);
    end

    drain_wait();
    repeat (4) @(posedge clk);

    $display("Ran %0d push, %0d pop-front, %0d pop-back, %0d read operations",
             op_hits[OP_PUSH], op_hits[OP_POP_FRONT], op_hits[OP_POP_BACK],
             op_hits[OP_READ_AT]);
    $display("Checked %0d results, %0d refused on full/empty/out-of-range, %0d errors",
             n_checked, n_refused, errors);
    if (errors == 0 && ring_resp_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
